[src/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg: shared definitions for the infix to postfix converter
// Token codes, status codes, stack sizing, result and RAM port types.
// ----------------------------------------------------------------------------
package itp_pkg;

	// Stack sizing and operand handle width.
	localparam int STACK_DEPTH   = 32;
	localparam int OPERAND_WIDTH = 32;
	localparam int VALUE_W       = 32;
	localparam int PTR_W         = $clog2(STACK_DEPTH);
	localparam int CNT_W         = $clog2(STACK_DEPTH + 1);

	// Mask applied to incoming operand handles.
	localparam logic [VALUE_W-1:0] OPERAND_MASK = (OPERAND_WIDTH >= VALUE_W) ? '1 :
		VALUE_W'((65'd1 << OPERAND_WIDTH) - 65'd1);

	// Token kinds.
	localparam logic [2:0] K_OPERAND = 3'd0;
	localparam logic [2:0] K_PLUS    = 3'd1;
	localparam logic [2:0] K_MINUS   = 3'd2;
	localparam logic [2:0] K_TIMES   = 3'd3;
	localparam logic [2:0] K_DIVIDE  = 3'd4;
	localparam logic [2:0] K_OPEN    = 3'd5;
	localparam logic [2:0] K_CLOSE   = 3'd6;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_PAREN = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;

	// Converter sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_PROC,
		S_FLUSH,
		S_ERR
	} state_t;

	// One result word.
	typedef struct packed {
		logic [2:0]         kind;
		logic [VALUE_W-1:0] value;
		logic [1:0]         status;
		logic               done;
		logic               last;
	} res_t;

	// Write port of the operator stack RAM.
	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		logic [2:0]       data;
	} ram_wr_t;

	// Operator priority: + and - rank 1, * and / rank 2, anything else 0.
	function automatic logic [1:0] rank_of(input logic [2:0] k);
		logic [1:0] r;
		case (k) inside
			K_PLUS, K_MINUS:  r = 2'd1;
			K_TIMES, K_DIVIDE: r = 2'd2;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

[src/itp_stack_ram.sv]
// ----------------------------------------------------------------------------
// itp_stack_ram: operator stack storage
// Single write port and one synchronous, registered read port.
// ----------------------------------------------------------------------------
module itp_stack_ram
	import itp_pkg::*;
(
	input  logic             clk,
	input  ram_wr_t          wr,
	input  logic [PTR_W-1:0] rd_addr,
	output logic [2:0]       rd_data
);

	logic [2:0] mem [STACK_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[src/infix_to_postfix_converter.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
// Operator stack held in a synchronous RAM, top entry read every cycle.
// ----------------------------------------------------------------------------
//  Channel  | Handshake             | Word
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_ready   | token_kind, token_close, operand_value,
//           |                       | end_of_expression
//  output   | out_valid / out_ready | out_kind, out_value, status, expr_done,
//           |                       | run_last
//
//  A token is taken in S_IDLE and handled in S_PROC. Operators are popped
//  one by one, the stack RAM giving one new top entry per cycle while the
//  holding word can move on. An end token then flushes the rest of the stack
//  in S_FLUSH; an error in S_ERR sends any held word, then the error word.
//  Reset clears the stack count, the discard flag and all valid flags; the
//  stack RAM itself is not cleared. A stalled output holds the pop loop
//  while a held result waits and a finished word waits in the output register.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
	import itp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         token_kind,
	input  logic               token_close,
	input  logic [VALUE_W-1:0] operand_value,
	input  logic               end_of_expression,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         out_kind,
	output logic [VALUE_W-1:0] out_value,
	output logic [1:0]         status,
	output logic               expr_done,
	output logic               run_last
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               disc_q, disc_d;
	logic [1:0]         err_q, err_d;

	logic [2:0]         tok_kind_q;
	logic               tok_close_q;
	logic [VALUE_W-1:0] tok_value_q;
	logic               tok_end_q;

	logic               pend_v_q;
	res_t               pend_q, pend_new;
	logic               pend_ld, pend_clr;

	logic               out_valid_q;
	res_t               out_q, out_d;
	logic               out_ld, out_free;

	ram_wr_t            wr;
	logic [PTR_W-1:0]   rd_addr;
	logic [2:0]         rd_data;
	logic [CNT_W-1:0]   cnt_m1;
	logic               fwd_v_q;
	logic [2:0]         fwd_q;
	logic [2:0]         top;
	logic               not_empty, full, ok, pop_ok;
	logic               do_pop, do_push;
	logic               accept;

	// Operator stack storage.
	itp_stack_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The read address always follows the next top, so the registered read holds the top in the next cycle.
	assign cnt_m1  = count_d - CNT_W'(1);
	assign rd_addr = (count_d == '0) ? '0 : cnt_m1[PTR_W-1:0];

	// A push writes the entry that is read in the same cycle, so it is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_q <= wr.data;
	end

	assign top       = fwd_v_q ? fwd_q : rd_data;
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign out_free  = !out_valid_q || out_ready;
	assign pop_ok    = !pend_v_q || out_free;
	assign ok        = tok_end_q || pop_ok;
	assign accept    = in_valid && in_ready;

	// Next state and actions of the sequencer.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		disc_d   = disc_q;
		err_d    = err_q;
		wr       = '0;
		pend_ld  = 1'b0;
		pend_clr = 1'b0;
		pend_new = '0;
		out_ld   = 1'b0;
		out_d    = pend_q;
		in_ready = 1'b0;
		do_pop   = 1'b0;
		do_push  = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (disc_q) begin
						if (end_of_expression) begin
							disc_d  = 1'b0;
							count_d = '0;
						end
					end else begin
						state_d = S_PROC;
					end
				end
			end

			S_PROC: begin
				if (tok_close_q) begin
					if (not_empty && top != K_OPEN) begin
						do_pop = pop_ok;
					end else if (!not_empty) begin
						err_d   = ST_PAREN;
						state_d = S_ERR;
					end else if (ok) begin
						// Matching open parenthesis is dropped.
						count_d = count_q - CNT_W'(1);
						state_d = S_IDLE;
					end
				end else if (tok_kind_q == K_OPERAND) begin
					if (tok_end_q) begin
						pend_ld  = 1'b1;
						pend_new = '{kind: K_OPERAND, value: tok_value_q, status: ST_OK,
							done: 1'b0, last: 1'b0};
						state_d  = S_FLUSH;
					end else if (out_free) begin
						out_ld  = 1'b1;
						out_d   = '{kind: K_OPERAND, value: tok_value_q, status: ST_OK,
							done: 1'b0, last: 1'b1};
						state_d = S_IDLE;
					end
				end else if (tok_kind_q inside {[K_PLUS:K_DIVIDE]}) begin
					if (not_empty && top != K_OPEN &&
						rank_of(top) >= rank_of(tok_kind_q)) begin
						do_pop = pop_ok;
					end else if (full) begin
						err_d   = ST_OVER;
						state_d = S_ERR;
					end else if (ok) begin
						do_push = 1'b1;
						state_d = S_IDLE;
					end
				end else if (tok_kind_q == K_OPEN) begin
					if (full) begin
						err_d   = ST_OVER;
						state_d = S_ERR;
					end else if (ok) begin
						do_push = 1'b1;
						state_d = S_IDLE;
					end
				end else if (ok) begin
					// Unused kind code: no result of its own.
					state_d = S_IDLE;
				end

				// Token finished without error: flush, or close the run of results.
				if (state_d == S_IDLE) begin
					if (tok_end_q) begin
						state_d = S_FLUSH;
					end else if (pend_v_q) begin
						out_ld     = 1'b1;
						out_d      = pend_q;
						out_d.last = 1'b1;
						pend_clr   = 1'b1;
					end
				end
			end

			S_FLUSH: begin
				if (not_empty) begin
					if (top == K_OPEN) begin
						err_d   = ST_PAREN;
						state_d = S_ERR;
					end else begin
						do_pop = pop_ok;
					end
				end else if (out_free) begin
					out_ld = 1'b1;
					if (pend_v_q) begin
						out_d      = pend_q;
						out_d.done = 1'b1;
						out_d.last = 1'b1;
						pend_clr   = 1'b1;
					end else begin
						out_d = '{kind: K_OPERAND, value: '0, status: ST_OK,
							done: 1'b1, last: 1'b1};
					end
					state_d = S_IDLE;
				end
			end

			S_ERR: begin
				if (out_free) begin
					out_ld = 1'b1;
					if (pend_v_q) begin
						// Results popped before the error go out first.
						out_d    = pend_q;
						pend_clr = 1'b1;
					end else begin
						out_d   = '{kind: K_OPERAND, value: '0, status: err_q,
							done: 1'b1, last: 1'b1};
						count_d = '0;
						disc_d  = !tok_end_q;
						state_d = S_IDLE;
					end
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Pop the top operator into the holding word; the older word leaves.
		if (do_pop) begin
			count_d  = count_q - CNT_W'(1);
			pend_ld  = 1'b1;
			pend_new = '{kind: top, value: '0, status: ST_OK, done: 1'b0, last: 1'b0};
			if (pend_v_q) begin
				out_ld = 1'b1;
				out_d  = pend_q;
			end
		end

		// Push the token onto the stack.
		if (do_push) begin
			wr.en   = 1'b1;
			wr.addr = count_q[PTR_W-1:0];
			wr.data = tok_kind_q;
			count_d = count_q + CNT_W'(1);
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			disc_q  <= 1'b0;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			disc_q  <= disc_d;
			err_q   <= err_d;
		end
	end

	// Token capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			tok_kind_q  <= token_kind;
			tok_close_q <= token_close || (token_kind == K_CLOSE);
			tok_value_q <= operand_value & OPERAND_MASK;
			tok_end_q   <= end_of_expression;
		end
	end

	// Holding word: the newest result, kept until it is known whether it is the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (pend_ld) begin
			pend_v_q <= 1'b1;
		end else if (pend_clr) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_ld) begin
			pend_q <= pend_new;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_q.kind;
	assign out_value = out_q.value;
	assign status    = out_q.status;
	assign expr_done = out_q.done;
	assign run_last  = out_q.last;

`ifndef SYNTHESIS
	// The stack count never passes the stack depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// No push is made onto a full stack.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !full)
		else $error("push onto a full stack");

	// While tokens are dropped the stack is empty.
	a_disc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> count_q == '0)
		else $error("stack not empty while discarding");

	// Every held result has left before the next token is taken.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("held result left behind at idle");
`endif

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the infix to postfix converter
// Tokens are driven through the input handshake and the postfix words coming
// back are checked against an in-bench shunting-yard predictor. Directed
// expressions cover precedence, parentheses, errors and end markers. The
// random part is mostly well-formed expressions with random content, plus
// broken ones and noise. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import itp_pkg::*;

	localparam logic [2:0] K_SPARE      = 3'd7;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         DRAIN_CYCLES = 60;
	localparam int         HOLD_CYCLES  = 200;

	// One infix token as presented on the input channel.
	typedef struct packed {
		logic [2:0]         kind;
		logic               close;
		logic [VALUE_W-1:0] value;
		logic               eoe;
	} token_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         token_kind = '0;
	logic               token_close = 1'b0;
	logic [VALUE_W-1:0] operand_value = '0;
	logic               end_of_expression = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         out_kind;
	logic [VALUE_W-1:0] out_value;
	logic [1:0]         status;
	logic               expr_done;
	logic               run_last;

	// Predictor state: operator stack, its fill level and the discard flag.
	logic [2:0] op_stack [STACK_DEPTH];
	int         depth_count = 0;
	bit         discarding = 1'b0;

	res_t   awaited_words [$];
	token_t expr_tokens [$];
	int     error_count = 0;
	int     cycle_count = 0;
	int     items_sent = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     hold_left = 0;

	infix_to_postfix_converter u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.token_kind       (token_kind),
		.token_close      (token_close),
		.operand_value    (operand_value),
		.end_of_expression(end_of_expression),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_kind         (out_kind),
		.out_value        (out_value),
		.status           (status),
		.expr_done        (expr_done),
		.run_last         (run_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit, so that a hung block still ends the simulation.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: a long hold-off when one is requested, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Each accepted output word is compared with the oldest awaited word.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_words.size() == 0) begin
				report_mismatch("word with none awaited", out_value, '0);
			end else begin
				want = awaited_words.pop_front();
				if (out_kind !== want.kind)
					report_mismatch("out_kind", 32'(out_kind), 32'(want.kind));
				if (out_value !== want.value)
					report_mismatch("out_value", out_value, want.value);
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (expr_done !== want.done)
					report_mismatch("expr_done", 32'(expr_done), 32'(want.done));
				if (run_last !== want.last)
					report_mismatch("run_last", 32'(run_last), 32'(want.last));
			end
		end
	end

	function automatic int precedence_of(input logic [2:0] k);
		if (k == K_PLUS || k == K_MINUS)
			return 1;
		if (k == K_TIMES || k == K_DIVIDE)
			return 2;
		return 0;
	endfunction

	function automatic res_t make_word(input logic [2:0] k, input logic [VALUE_W-1:0] v,
			input logic [1:0] st, input logic done);
		res_t w;
		w.kind   = k;
		w.value  = v;
		w.status = st;
		w.done   = done;
		w.last   = 1'b0;
		return w;
	endfunction

	// Shunting-yard step for one accepted token; appends the words it causes.
	function automatic void predict_postfix(input token_t t);
		res_t       run [$];
		res_t       w;
		logic [1:0] err;
		logic [2:0] top;
		bit         is_close;
		int         r;
		err = ST_OK;
		is_close = t.close || (t.kind == K_CLOSE);
		if (discarding) begin
			if (t.eoe) begin
				discarding = 1'b0;
				depth_count = 0;
			end
			return;
		end
		if (is_close) begin
			while (depth_count > 0 && op_stack[depth_count - 1] != K_OPEN) begin
				depth_count--;
				run.push_back(make_word(op_stack[depth_count], '0, ST_OK, 1'b0));
			end
			if (depth_count == 0)
				err = ST_PAREN;
			else
				depth_count--;
		end else if (t.kind == K_OPERAND) begin
			run.push_back(make_word(K_OPERAND, t.value & OPERAND_MASK, ST_OK, 1'b0));
		end else if (t.kind <= K_DIVIDE) begin
			r = precedence_of(t.kind);
			while (depth_count > 0 && op_stack[depth_count - 1] != K_OPEN &&
					precedence_of(op_stack[depth_count - 1]) >= r) begin
				depth_count--;
				run.push_back(make_word(op_stack[depth_count], '0, ST_OK, 1'b0));
			end
			if (depth_count >= STACK_DEPTH) begin
				err = ST_OVER;
			end else begin
				op_stack[depth_count] = t.kind;
				depth_count++;
			end
		end else if (t.kind == K_OPEN) begin
			if (depth_count >= STACK_DEPTH) begin
				err = ST_OVER;
			end else begin
				op_stack[depth_count] = K_OPEN;
				depth_count++;
			end
		end

		// End of expression: flush everything, an open paren left over is an error.
		if (err == ST_OK && t.eoe) begin
			while (depth_count > 0 && err == ST_OK) begin
				depth_count--;
				top = op_stack[depth_count];
				if (top == K_OPEN)
					err = ST_PAREN;
				else
					run.push_back(make_word(top, '0, ST_OK, 1'b0));
			end
			if (err == ST_OK) begin
				if (run.size() == 0) begin
					run.push_back(make_word(K_OPERAND, '0, ST_OK, 1'b1));
				end else begin
					w = run.pop_back();
					w.done = 1'b1;
					run.push_back(w);
				end
			end
		end

		if (err != ST_OK) begin
			run.push_back(make_word(K_OPERAND, '0, err, 1'b1));
			depth_count = 0;
			discarding = !t.eoe;
		end

		if (run.size() > 0) begin
			w = run.pop_back();
			w.last = 1'b1;
			run.push_back(w);
		end
		foreach (run[i])
			awaited_words.push_back(run[i]);
	endfunction

	function automatic token_t make_token(input logic [2:0] k, input logic cl,
			input logic [VALUE_W-1:0] v, input logic eoe);
		token_t t;
		t.kind  = k;
		t.close = cl;
		t.value = v;
		t.eoe   = eoe;
		return t;
	endfunction

	function automatic logic [2:0] random_operator();
		return 3'($urandom_range(K_PLUS, K_DIVIDE));
	endfunction

	// A close paren either by its own kind or by the override flag.
	function automatic token_t random_close();
		if ($urandom_range(1))
			return make_token(K_CLOSE, 1'b0, $urandom(), 1'b0);
		return make_token(3'($urandom_range(7)), 1'b1, $urandom(), 1'b0);
	endfunction

	function automatic token_t noise_token();
		return make_token(3'($urandom_range(7)), $urandom_range(3) == 0, $urandom(),
			$urandom_range(5) == 0);
	endfunction

	// Builds a well-formed infix expression into the token list.
	function automatic void build_expression(input int terms, input int max_nest);
		int open_level;
		open_level = 0;
		expr_tokens.delete();
		for (int i = 0; i < terms; i++) begin
			if (i > 0)
				expr_tokens.push_back(make_token(random_operator(), 1'b0, $urandom(), 1'b0));
			while (open_level < max_nest && $urandom_range(3) == 0) begin
				expr_tokens.push_back(make_token(K_OPEN, 1'b0, $urandom(), 1'b0));
				open_level++;
			end
			expr_tokens.push_back(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
			while (open_level > 0 && $urandom_range(2) == 0) begin
				expr_tokens.push_back(random_close());
				open_level--;
			end
		end
		while (open_level > 0) begin
			expr_tokens.push_back(random_close());
			open_level--;
		end
	endfunction

	// Marks the last token of the list as the end of the expression.
	function automatic void close_expression();
		token_t t;
		if (expr_tokens.size() == 0)
			expr_tokens.push_back(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
		t = expr_tokens.pop_back();
		t.eoe = 1'b1;
		expr_tokens.push_back(t);
	endfunction

	// Sends one word, with random idle cycles ahead of it, and predicts its results.
	task automatic send_token(input token_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		token_kind        <= t.kind;
		token_close       <= t.close;
		operand_value     <= t.value;
		end_of_expression <= t.eoe;
		in_valid          <= 1'b1;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		if (!discarding && !(t.kind == K_SPARE && !t.close))
			items_sent++;
		predict_postfix(t);
	endtask

	task automatic send_expression();
		foreach (expr_tokens[i])
			send_token(expr_tokens[i]);
	endtask

	// Stops sending and waits until every awaited word has come back.
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	// a + b * c - d / e, with the extreme operand values.
	task automatic test_precedence();
		send_token(make_token(K_OPERAND, 1'b0, '1, 1'b0));
		send_token(make_token(K_PLUS, 1'b0, '1, 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, '0, 1'b0));
		send_token(make_token(K_TIMES, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_MINUS, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_DIVIDE, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b1));
		wait_for_results();
	endtask

	// ( a - b ) * c, the close paren given by the override flag.
	task automatic test_parentheses();
		send_token(make_token(K_OPEN, 1'b0, '0, 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_MINUS, 1'b0, '0, 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_PLUS, 1'b1, $urandom(), 1'b0));
		send_token(make_token(K_TIMES, 1'b0, '0, 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b1));
		wait_for_results();
	endtask

	// An unmatched close paren, dropped tokens, then an open paren left at the end.
	task automatic test_error_recovery();
		send_token(make_token(K_OPEN, 1'b1, '1, 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_PLUS, 1'b0, '0, 1'b1));
		send_token(make_token(K_OPEN, 1'b0, '0, 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b1));
		wait_for_results();
	endtask

	// End tokens with nothing to emit, and the spare kind being ignored.
	task automatic test_end_markers();
		send_token(make_token(K_OPEN, 1'b0, '0, 1'b0));
		send_token(make_token(K_CLOSE, 1'b0, '1, 1'b1));
		send_token(make_token(K_SPARE, 1'b0, $urandom(), 1'b1));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_SPARE, 1'b0, $urandom(), 1'b0));
		send_token(make_token(K_PLUS, 1'b0, '0, 1'b0));
		send_token(make_token(K_OPERAND, 1'b0, $urandom(), 1'b1));
		wait_for_results();
	endtask

	// Fills the stack to the brim, then pushes one more entry.
	task automatic test_stack_overflow();
		// Open paren onto a full stack, mid-expression, so the rest is dropped.
		expr_tokens.delete();
		for (int i = 0; i < STACK_DEPTH / 2; i++) begin
			expr_tokens.push_back(make_token(K_OPEN, 1'b0, $urandom(), 1'b0));
			if ($urandom_range(1))
				expr_tokens.push_back(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
			expr_tokens.push_back(make_token(random_operator(), 1'b0, $urandom(), 1'b0));
		end
		expr_tokens.push_back(make_token(K_OPEN, 1'b0, $urandom(), 1'b0));
		expr_tokens.push_back(make_token(K_OPERAND, 1'b0, $urandom(), 1'b0));
		expr_tokens.push_back(make_token(K_OPERAND, 1'b0, $urandom(), 1'b1));
		send_expression();

		// Operator onto a full stack, on the last token of the expression.
		expr_tokens.delete();
		for (int i = 0; i < STACK_DEPTH / 2 - 1; i++) begin
			expr_tokens.push_back(make_token(K_OPEN, 1'b0, $urandom(), 1'b0));
			expr_tokens.push_back(make_token(random_operator(), 1'b0, $urandom(), 1'b0));
		end
		expr_tokens.push_back(make_token(K_OPEN, 1'b0, $urandom(), 1'b0));
		expr_tokens.push_back(make_token(K_PLUS, 1'b0, $urandom(), 1'b0));
		expr_tokens.push_back(make_token(K_TIMES, 1'b0, $urandom(), 1'b1));
		send_expression();
		wait_for_results();
	endtask

	// Mostly well-formed expressions, some broken ones and some pure noise.
	task automatic test_random_expressions(input int quota);
		int start_count;
		int pick;
		int pos;
		start_count = items_sent;
		while (items_sent - start_count < quota) begin
			pick = $urandom_range(9);
			if (pick == 0) begin
				expr_tokens.delete();
				repeat ($urandom_range(1, 6)) expr_tokens.push_back(noise_token());
			end else begin
				build_expression($urandom_range(1, 6), $urandom_range(0, 4));
				pos = $urandom_range(expr_tokens.size() - 1);
				// Break the expression: drop a token, or slip in a stray one.
				if (pick == 1)
					expr_tokens.delete(pos);
				else if (pick == 2 && $urandom_range(1))
					expr_tokens.insert(pos, make_token(K_OPEN, 1'b0, $urandom(), 1'b0));
				else if (pick == 2)
					expr_tokens.insert(pos, random_close());
				else if (pick == 3)
					expr_tokens.insert(pos, make_token(K_SPARE, 1'b0, $urandom(), 1'b0));
			end
			close_expression();
			send_expression();
		end
		wait_for_results();
	endtask

	// The receiver holds off while a long expression keeps the sender busy.
	task automatic test_output_backpressure();
		build_expression(30, 0);
		close_expression();
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		send_expression();
		wait_for_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idling(29, 57);
		test_precedence();
		test_parentheses();
		test_error_recovery();
		test_end_markers();
		test_stack_overflow();
		test_random_expressions(20);
		set_idling(57, 29);
		test_random_expressions(20);
		set_idling(0, 0);
		test_random_expressions(20);
		test_output_backpressure();

		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
src/itp_pkg.sv
src/itp_stack_ram.sv
src/infix_to_postfix_converter.sv
dv/testbench.sv
